>>> src/vftl_pkg.sv
// Shared constants and types for the trilinear vector field lookup.
package vftl_pkg;

   localparam int GRID_X_DEFAULT = 32;
   localparam int GRID_Y_DEFAULT = 32;
   localparam int GRID_Z_DEFAULT = 32;

   localparam int COORD_W  = 32;
   localparam int STEP_W   = 20;
   localparam int INDEX_W  = 5;
   localparam int FIELD_W  = 24;
   localparam int FRAC_W   = 16;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int QUOT_W   = COORD_W + FRAC_W;
   localparam int CORNERS  = 8;
   localparam int LERPS    = 7;
   localparam int LANES    = 3;

   localparam logic [5:0] DIV_LAST = 6'(QUOT_W - 1);
   localparam logic [STEP_W-1:0] STEP_RESET = 20'd1024;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_ORIGIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Z_ORIGIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_STEP   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_Z_STEP   = 3'd5;

   localparam logic FUNC_STORE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic       load_query;
      logic       div_step;
      logic       rd_en;
      logic [2:0] rd_corner;
      logic       lerp_mul;
      logic       lerp_add;
      logic [2:0] lerp_step;
      logic       emit_hit;
      logic       emit_miss;
   } cmd_type;

endpackage

>>> src/vftl_div.sv
// Radix-2 restoring divider giving floor(d * 65536 / step), one bit per cycle while step_en is high.
module vftl_div (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic                                     step_en,
   input  logic [vftl_pkg::COORD_W-1:0]             dividend,
   input  logic [vftl_pkg::STEP_W-1:0]              divisor,
   output logic [vftl_pkg::QUOT_W-1:0]              quotient
);

   logic [vftl_pkg::QUOT_W-1:0] n_ff, n_in;
   logic [vftl_pkg::STEP_W-1:0] r_ff, r_in;
   logic [vftl_pkg::STEP_W:0]   r_shift;
   logic                        q_bit;

   always_comb begin
      r_shift = {r_ff, n_ff[vftl_pkg::QUOT_W-1]};
      q_bit   = (r_shift >= {1'b0, divisor});
      n_in    = n_ff;
      r_in    = r_ff;
      if (load) begin
         n_in = {dividend, {vftl_pkg::FRAC_W{1'b0}}};
         r_in = '0;
      end else if (step_en) begin
         n_in = {n_ff[vftl_pkg::QUOT_W-2:0], q_bit};
         if (q_bit) begin
            r_in = vftl_pkg::STEP_W'(r_shift - {1'b0, divisor});
         end else begin
            r_in = r_shift[vftl_pkg::STEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
   end

   assign quotient = n_ff;

endmodule

>>> src/vftl_ctrl.sv
// Controller sequencing division, corner reads and interpolation steps.
module vftl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_func,
   input  logic              miss,
   output logic              busy,
   output logic              rsp_valid,
   output vftl_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE, DIVIDE, CHECK, READ, DRAIN, LMUL, LADD, EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       busy_ff, valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (start && req_func == vftl_pkg::FUNC_QUERY) begin
               cmd.load_query = 1'b1;
               state_in = DIVIDE;
               cnt_in   = '0;
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == vftl_pkg::DIV_LAST) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            cnt_in = '0;
            if (miss) begin
               cmd.emit_miss = 1'b1;
               valid_in = 1'b1;
               state_in = IDLE;
            end else begin
               state_in = READ;
            end
         end
         READ: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_corner = cnt_ff[2:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[2:0] == 3'(vftl_pkg::CORNERS - 1)) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            cnt_in   = '0;
            state_in = LMUL;
         end
         LMUL: begin
            cmd.lerp_mul  = 1'b1;
            cmd.lerp_step = cnt_ff[2:0];
            state_in = LADD;
         end
         LADD: begin
            cmd.lerp_add  = 1'b1;
            cmd.lerp_step = cnt_ff[2:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[2:0] == 3'(vftl_pkg::LERPS - 1)) begin
               state_in = EMIT;
            end else begin
               state_in = LMUL;
            end
         end
         EMIT: begin
            cmd.emit_hit = 1'b1;
            valid_in = 1'b1;
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= (state_in != IDLE);
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

>>> src/vftl_datapath.sv
// Datapath: config registers, grid memory, dividers, corner queue and lerp unit.
module vftl_datapath #(
   parameter int GRID_X = vftl_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = vftl_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = vftl_pkg::GRID_Z_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  vftl_pkg::cmd_type                           cmd,
   input  logic                                        store_en,
   output logic                                        miss,
   input  logic                                        csr_wr_en,
   input  logic        [vftl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic        [vftl_pkg::COORD_W-1:0]         csr_wr_data,
   input  logic        [vftl_pkg::INDEX_W-1:0]         req_grid_x,
   input  logic        [vftl_pkg::INDEX_W-1:0]         req_grid_y,
   input  logic        [vftl_pkg::INDEX_W-1:0]         req_grid_z,
   input  logic signed [vftl_pkg::FIELD_W-1:0]         req_store_bx,
   input  logic signed [vftl_pkg::FIELD_W-1:0]         req_store_by,
   input  logic signed [vftl_pkg::FIELD_W-1:0]         req_store_bz,
   input  logic signed [vftl_pkg::COORD_W-1:0]         req_point_x,
   input  logic signed [vftl_pkg::COORD_W-1:0]         req_point_y,
   input  logic signed [vftl_pkg::COORD_W-1:0]         req_point_z,
   output logic                                        rsp_found,
   output logic signed [vftl_pkg::FIELD_W-1:0]         rsp_field_x,
   output logic signed [vftl_pkg::FIELD_W-1:0]         rsp_field_y,
   output logic signed [vftl_pkg::FIELD_W-1:0]         rsp_field_z
);

   localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);
   localparam int CW    = vftl_pkg::COORD_W;
   localparam int FW    = vftl_pkg::FIELD_W;
   localparam int WW    = vftl_pkg::WEIGHT_W;
   localparam int QW    = vftl_pkg::QUOT_W;
   localparam int FRW   = vftl_pkg::FRAC_W;
   localparam int PW    = FW + WW + 1;

   logic signed [CW-1:0] org_ff [3];
   logic [vftl_pkg::STEP_W-1:0] step_ff [3];

   logic signed [CW-1:0] point [3];
   logic        [CW:0]   diff [3];
   logic                 pre_miss_ff, pre_miss_in;
   logic        [QW-1:0] quot [3];
   logic        [2:0]    lane_miss;
   logic        [FRW-1:0] w2 [3];
   logic        [WW-1:0]  w1 [3];

   logic [3*FW-1:0] mem [DEPTH];
   logic [3*FW-1:0] rd_data_ff;
   logic            rd_valid_ff;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [XW-1:0]   cx;
   logic [YW-1:0]   cy;
   logic [ZW-1:0]   cz;
   logic            store_ok;

   logic signed [FW-1:0] q_ff [8][3];
   logic signed [FW-1:0] q_in [8][3];
   logic signed [PW-1:0] p1_ff [3];
   logic signed [PW-1:0] p2_ff [3];
   logic signed [PW:0]   acc [3];
   logic signed [FW-1:0] lres [3];
   logic [WW-1:0]  sel_w1;
   logic [FRW-1:0] sel_w2;
   logic [2:0]     wr_slot;

   logic                 found_ff;
   logic signed [FW-1:0] out_ff [3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0]  <= '0;
         org_ff[1]  <= '0;
         org_ff[2]  <= '0;
         step_ff[0] <= vftl_pkg::STEP_RESET;
         step_ff[1] <= vftl_pkg::STEP_RESET;
         step_ff[2] <= vftl_pkg::STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            vftl_pkg::CSR_X_ORIGIN: org_ff[0]  <= csr_wr_data;
            vftl_pkg::CSR_Y_ORIGIN: org_ff[1]  <= csr_wr_data;
            vftl_pkg::CSR_Z_ORIGIN: org_ff[2]  <= csr_wr_data;
            vftl_pkg::CSR_X_STEP:   step_ff[0] <= csr_wr_data[vftl_pkg::STEP_W-1:0];
            vftl_pkg::CSR_Y_STEP:   step_ff[1] <= csr_wr_data[vftl_pkg::STEP_W-1:0];
            vftl_pkg::CSR_Z_STEP:   step_ff[2] <= csr_wr_data[vftl_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // offset from origin and early miss flags
   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      pre_miss_in = pre_miss_ff;
      for (int a = 0; a < 3; a++) begin
         diff[a] = {point[a][CW-1], point[a]} - {org_ff[a][CW-1], org_ff[a]};
      end
      if (cmd.load_query) begin
         pre_miss_in = 1'b0;
         for (int a = 0; a < 3; a++) begin
            if (diff[a][CW] || step_ff[a] == '0) begin
               pre_miss_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_miss_ff <= pre_miss_in;
   end

   for (genvar a = 0; a < 3; a++) begin : g_div
      vftl_div u_div (
         .clock    (clock),
         .load     (cmd.load_query),
         .step_en  (cmd.div_step),
         .dividend (diff[a][CW-1:0]),
         .divisor  (step_ff[a]),
         .quotient (quot[a])
      );
      assign w2[a] = quot[a][FRW-1:0];
      assign w1[a] = WW'(1 << FRW) - {1'b0, w2[a]};
   end

   assign lane_miss[0] = quot[0][QW-1:FRW] >= CW'(GRID_X - 1);
   assign lane_miss[1] = quot[1][QW-1:FRW] >= CW'(GRID_Y - 1);
   assign lane_miss[2] = quot[2][QW-1:FRW] >= CW'(GRID_Z - 1);
   assign miss = pre_miss_ff || (|lane_miss);

   // grid memory
   assign store_ok = (32'(req_grid_x) < 32'(GRID_X)) &&
                     (32'(req_grid_y) < 32'(GRID_Y)) &&
                     (32'(req_grid_z) < 32'(GRID_Z));
   assign wr_addr = AW'(req_grid_x) * AW'(GRID_Y * GRID_Z) +
                    AW'(req_grid_y) * AW'(GRID_Z) + AW'(req_grid_z);

   assign cx = quot[0][FRW +: XW] + XW'(cmd.rd_corner[0]);
   assign cy = quot[1][FRW +: YW] + YW'(cmd.rd_corner[1]);
   assign cz = quot[2][FRW +: ZW] + ZW'(cmd.rd_corner[2]);
   assign rd_addr = AW'(cx) * AW'(GRID_Y * GRID_Z) + AW'(cy) * AW'(GRID_Z) + AW'(cz);

   always_ff @(posedge clock) begin
      if (store_en && store_ok) begin
         mem[wr_addr] <= {req_store_bz, req_store_by, req_store_bx};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   // interpolation: multiply stage then sum and round
   always_comb begin
      if (cmd.lerp_step < 3'd4) begin
         sel_w1 = w1[0];
         sel_w2 = w2[0];
      end else if (cmd.lerp_step < 3'd6) begin
         sel_w1 = w1[1];
         sel_w2 = w2[1];
      end else begin
         sel_w1 = w1[2];
         sel_w2 = w2[2];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lerp_mul) begin
         for (int c = 0; c < 3; c++) begin
            p1_ff[c] <= PW'($signed({1'b0, sel_w1}) * q_ff[0][c]);
            p2_ff[c] <= PW'($signed({2'b0, sel_w2}) * q_ff[1][c]);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c]  = (PW+1)'(p1_ff[c]) + (PW+1)'(p2_ff[c]) + (PW+1)'(1 << (FRW - 1));
         lres[c] = FW'(acc[c] >>> FRW);
      end
   end

   // corner queue: pop pairs from the head, push results behind the remainder
   assign wr_slot = 3'd6 - cmd.lerp_step;

   always_comb begin
      q_in = q_ff;
      if (rd_valid_ff) begin
         for (int i = 0; i < 7; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         q_in[7][0] = rd_data_ff[0 +: FW];
         q_in[7][1] = rd_data_ff[FW +: FW];
         q_in[7][2] = rd_data_ff[2*FW +: FW];
      end else if (cmd.lerp_add) begin
         for (int i = 0; i < 6; i++) begin
            q_in[i] = q_ff[i + 2];
         end
         for (int i = 0; i < 8; i++) begin
            if (3'(i) == wr_slot) begin
               q_in[i] = lres;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.emit_hit) begin
         found_ff <= 1'b1;
         out_ff   <= q_ff[0];
      end else if (cmd.emit_miss) begin
         found_ff  <= 1'b0;
         out_ff[0] <= '0;
         out_ff[1] <= '0;
         out_ff[2] <= '0;
      end
   end

   assign rsp_found   = found_ff;
   assign rsp_field_x = out_ff[0];
   assign rsp_field_y = out_ff[1];
   assign rsp_field_z = out_ff[2];

endmodule

>>> src/vector_field_trilinear_lookup_core.sv
// Top level of the trilinear vector field lookup.
//
// Transactions enter on start while busy is low. req_func selects a store
// (writes one vector at req_grid_x/y/z, ignored if outside the grid) or a
// query (point in req_point_x/y/z). A store returns nothing. A query returns
// one transaction on rsp_valid, high for exactly one cycle, with rsp_found
// and the interpolated rsp_field_x/y/z. A query that hits runs bit-serial
// division on all three axes in parallel, one check state, 8 memory reads,
// one drain state, 7 interpolation steps of a multiply and an add, and one
// output state; a query that misses ends after the check. The dividers make
// one quotient bit per cycle while dividing. The next transaction may start
// in the cycle the result is shown. Configuration registers are written
// through csr_wr_en, csr_index and csr_wr_data; the user must write them
// only while the core is idle, which the core itself does not enforce. Reset
// clears the control logic and restores origins to 0 and steps to 1024; grid
// contents stay undefined until stored. The receiver cannot stall: results
// must be taken when shown.
module vector_field_trilinear_lookup_core #(
   parameter int GRID_X = vftl_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = vftl_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = vftl_pkg::GRID_Z_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_func,
   input  logic        [vftl_pkg::INDEX_W-1:0]     req_grid_x,
   input  logic        [vftl_pkg::INDEX_W-1:0]     req_grid_y,
   input  logic        [vftl_pkg::INDEX_W-1:0]     req_grid_z,
   input  logic signed [vftl_pkg::FIELD_W-1:0]     req_store_bx,
   input  logic signed [vftl_pkg::FIELD_W-1:0]     req_store_by,
   input  logic signed [vftl_pkg::FIELD_W-1:0]     req_store_bz,
   input  logic signed [vftl_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [vftl_pkg::COORD_W-1:0]     req_point_y,
   input  logic signed [vftl_pkg::COORD_W-1:0]     req_point_z,
   output logic                                    rsp_valid,
   output logic                                    rsp_found,
   output logic signed [vftl_pkg::FIELD_W-1:0]     rsp_field_x,
   output logic signed [vftl_pkg::FIELD_W-1:0]     rsp_field_y,
   output logic signed [vftl_pkg::FIELD_W-1:0]     rsp_field_z,
   input  logic                                    csr_wr_en,
   input  logic        [vftl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [vftl_pkg::COORD_W-1:0]     csr_wr_data
);

   vftl_pkg::cmd_type cmd;
   logic              miss;
   logic              store_en;

   assign store_en = start && !busy && (req_func == vftl_pkg::FUNC_STORE);

   vftl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start && !busy),
      .req_func  (req_func),
      .miss      (miss),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   vftl_datapath #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .store_en     (store_en),
      .miss         (miss),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_grid_x   (req_grid_x),
      .req_grid_y   (req_grid_y),
      .req_grid_z   (req_grid_z),
      .req_store_bx (req_store_bx),
      .req_store_by (req_store_by),
      .req_store_bz (req_store_bz),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_found    (rsp_found),
      .rsp_field_x  (rsp_field_x),
      .rsp_field_y  (rsp_field_y),
      .rsp_field_z  (rsp_field_z)
   );

endmodule
